// ===== rtl/npt_pkg.sv =====
package npt_pkg;

  // field widths
  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 48;
  localparam int POS_W      = 32;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 176;

  // most words a list request gives
  localparam int MAX_RESULTS = 16;
  localparam int LIST_CW     = $clog2(MAX_RESULTS + 1);

  // request codes
  localparam logic [OP_W-1:0] OP_SET    = 3'd0;
  localparam logic [OP_W-1:0] OP_GET    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_AGE    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // kind of walk over the slots
  typedef enum logic [1:0] {
    PASS_FIND = 2'd0,
    PASS_AGE  = 2'd1,
    PASS_OLD  = 2'd2,
    PASS_LIST = 2'd3
  } pass_t;

  // one stored neighbor
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] stamp;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic                load;
    logic                scan_start;
    logic                scan_run;
    pass_t               pass_kind;
    logic                apply_set;
    logic                apply_remove;
    logic                clear_all;
    logic                fetch;
    logic                take_best;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic                out_pos;
    logic                out_lst;
    logic                out_last;
  } npt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_done;
    logic            hit;
    logic            free;
    logic            best_found;
    logic            have_pend;
    logic            list_near;
    logic            out_free;
  } npt_stat_t;

endpackage

// ===== rtl/npt_dpath.sv =====
module npt_dpath #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [npt_pkg::OP_W-1:0]      in_tuser,
  input  logic [npt_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [npt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [npt_pkg::STATUS_W-1:0]  out_tuser,
  output logic                          out_tlast,
  input  npt_pkg::npt_cmd_t             cmd,
  output npt_pkg::npt_stat_t            stat
);
  import npt_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // request registers
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] cut_r;
  logic [POS_W-1:0]  px_r, py_r, pz_r;

  // table
  logic [ENTRIES-1:0] valid_r;
  slot_t              mem [ENTRIES];
  slot_t              rd_q;

  // walk
  logic [CW-1:0] cnt_r;
  logic          eval_en_r;
  logic [IW-1:0] eval_idx_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  // accumulators
  logic               hit_r, free_r;
  logic [IW-1:0]      hit_idx_r, free_idx_r;
  logic [TIME_W-1:0]  min_r;
  logic               best_found_r;
  logic [ADDR_W-1:0]  best_r;
  logic [LIST_CW-1:0] n_r;
  logic [ADDR_W-1:0]  pend_addr_r;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [POS_W-1:0]    ox_r, oy_r, oz_r;
  logic [ADDR_W-1:0]   olst_r;
  logic [TIME_W-1:0]   oold_r;
  logic                olast_r;

  logic          ev_valid;
  logic          find_hit, find_free, age_kill, old_less, list_cand;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic          out_free;

  // latch request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tuser;
      addr_r <= in_tdata[31:0];
      now_r  <= in_tdata[79:32];
      cut_r  <= in_tdata[127:80];
      px_r   <= in_tdata[159:128];
      py_r   <= in_tdata[191:160];
      pz_r   <= in_tdata[223:192];
    end
  end

  // slot evaluation for the current walk
  assign ev_valid  = valid_r[eval_idx_r];
  assign find_hit  = eval_en_r && (cmd.pass_kind == PASS_FIND) && ev_valid &&
                     (rd_q.addr == addr_r);
  assign find_free = eval_en_r && (cmd.pass_kind == PASS_FIND) && !ev_valid;
  assign age_kill  = eval_en_r && (cmd.pass_kind == PASS_AGE) && ev_valid &&
                     (rd_q.stamp <= cut_r);
  assign old_less  = eval_en_r && (cmd.pass_kind == PASS_OLD) && ev_valid &&
                     (rd_q.stamp < min_r);
  assign list_cand = eval_en_r && (cmd.pass_kind == PASS_LIST) && ev_valid &&
                     ((n_r == '0) || (rd_q.addr > pend_addr_r)) &&
                     (!best_found_r || (rd_q.addr < best_r));

  assign wr_en  = cmd.apply_set && (hit_r || free_r);
  assign wr_idx = hit_r ? hit_idx_r : free_idx_r;

  assign rd_en   = cmd.fetch || (cmd.scan_run && (cnt_r < CW'(ENTRIES)));
  assign rd_addr = cmd.fetch ? hit_idx_r : cnt_r[IW-1:0];

  // slot memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= '{addr: addr_r, stamp: now_r, x: px_r, y: py_r, z: pz_r};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.clear_all) begin
        valid_r <= '0;
      end
      if (age_kill) begin
        valid_r[eval_idx_r] <= 1'b0;
      end
      if (cmd.apply_remove && hit_r) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  // walk counter: read slot k, evaluate it in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      eval_en_r  <= 1'b0;
      eval_idx_r <= '0;
    end else if (cmd.scan_start) begin
      cnt_r     <= '0;
      eval_en_r <= 1'b0;
    end else if (cmd.scan_run) begin
      if (cnt_r < CW'(ENTRIES)) begin
        cnt_r      <= cnt_r + 1'b1;
        eval_en_r  <= 1'b1;
        eval_idx_r <= cnt_r[IW-1:0];
      end else begin
        eval_en_r <= 1'b0;
      end
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      best_found_r <= 1'b0;
      n_r          <= '0;
    end else begin
      if (cmd.scan_start) begin
        case (cmd.pass_kind)
          PASS_FIND: begin
            hit_r  <= 1'b0;
            free_r <= 1'b0;
          end
          PASS_OLD:  min_r <= '1;
          PASS_LIST: best_found_r <= 1'b0;
          default:   ;
        endcase
      end else begin
        if (find_hit) begin
          hit_r     <= 1'b1;
          hit_idx_r <= eval_idx_r;
        end
        if (find_free && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= eval_idx_r;
        end
        if (old_less) begin
          min_r <= rd_q.stamp;
        end
        if (list_cand) begin
          best_found_r <= 1'b1;
          best_r       <= rd_q.addr;
        end
      end
      if (cmd.load) begin
        n_r <= '0;
      end else if (cmd.take_best) begin
        n_r         <= n_r + 1'b1;
        pend_addr_r <= best_r;
      end
    end
  end

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      ox_r         <= cmd.out_pos ? rd_q.x : '0;
      oy_r         <= cmd.out_pos ? rd_q.y : '0;
      oz_r         <= cmd.out_pos ? rd_q.z : '0;
      olst_r       <= cmd.out_lst ? pend_addr_r : '0;
      oold_r       <= min_r;
      olast_r      <= cmd.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {oold_r, olst_r, oz_r, oy_r, ox_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = olast_r;

  // status to controller
  assign stat.op         = op_r;
  assign stat.scan_done  = (cnt_r == CW'(ENTRIES)) && !eval_en_r;
  assign stat.hit        = hit_r;
  assign stat.free       = free_r;
  assign stat.best_found = best_found_r;
  assign stat.have_pend  = (n_r != '0);
  assign stat.list_near  = (n_r == LIST_CW'(MAX_RESULTS - 1));
  assign stat.out_free   = out_free;

  // a word is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output word overwritten");

  // an address is stored in one slot at most
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    find_hit |-> !hit_r)
    else $error("address found in two slots");

  // listed addresses strictly ascend
  a_list_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_best && (n_r != '0)) |-> (best_r > pend_addr_r))
    else $error("list order broken");

  // a position read follows a hit
  a_fetch_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> hit_r)
    else $error("fetch without hit");

endmodule

// ===== rtl/npt_ctrl.sv =====
module npt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  npt_pkg::npt_stat_t stat,
  output npt_pkg::npt_cmd_t  cmd
);
  import npt_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_FIND   = 11'b000_0000_0100,
    S_APPLY  = 11'b000_0000_1000,
    S_AGE    = 11'b000_0001_0000,
    S_OLD    = 11'b000_0010_0000,
    S_FETCH  = 11'b000_0100_0000,
    S_EMIT   = 11'b000_1000_0000,
    S_LSCAN  = 11'b001_0000_0000,
    S_LSTEP  = 11'b010_0000_0000,
    S_LFIN   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   get_hit;

  assign get_hit = (stat.op == OP_GET) && stat.hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_start = 1'b1;
        case (stat.op)
          OP_SET, OP_GET, OP_REMOVE: begin
            cmd.pass_kind = PASS_FIND;
            state_nxt     = S_FIND;
          end
          OP_AGE: begin
            cmd.pass_kind = PASS_AGE;
            state_nxt     = S_AGE;
          end
          OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            cmd.pass_kind = PASS_OLD;
            state_nxt     = S_OLD;
          end
          default: begin
            cmd.pass_kind = PASS_OLD;
            state_nxt     = S_OLD;
          end
        endcase
      end
      S_FIND: begin
        cmd.scan_run  = 1'b1;
        cmd.pass_kind = PASS_FIND;
        if (stat.scan_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply_set    = (stat.op == OP_SET);
        cmd.apply_remove = (stat.op == OP_REMOVE);
        cmd.scan_start   = 1'b1;
        cmd.pass_kind    = PASS_OLD;
        state_nxt        = S_OLD;
      end
      S_AGE: begin
        cmd.scan_run  = 1'b1;
        cmd.pass_kind = PASS_AGE;
        if (stat.scan_done) begin
          cmd.scan_run   = 1'b0;
          cmd.scan_start = 1'b1;
          cmd.pass_kind  = PASS_OLD;
          state_nxt      = S_OLD;
        end
      end
      S_OLD: begin
        cmd.scan_run  = 1'b1;
        cmd.pass_kind = PASS_OLD;
        if (stat.scan_done) begin
          if (stat.op == OP_LIST) begin
            cmd.scan_run   = 1'b0;
            cmd.scan_start = 1'b1;
            cmd.pass_kind  = PASS_LIST;
            state_nxt      = S_LSCAN;
          end else if (get_hit) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_pos  = get_hit;
          case (stat.op)
            OP_SET:            cmd.out_status = (stat.hit || stat.free) ? ST_OK : ST_FULL;
            OP_GET, OP_REMOVE: cmd.out_status = stat.hit ? ST_OK : ST_MISS;
            OP_AGE, OP_CLEAR:  cmd.out_status = ST_OK;
            default:           cmd.out_status = ST_MISS;
          endcase
          state_nxt = S_IDLE;
        end
      end
      S_LSCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.pass_kind = PASS_LIST;
        if (stat.scan_done) begin
          state_nxt = S_LSTEP;
        end
      end
      S_LSTEP: begin
        cmd.pass_kind = PASS_LIST;
        if (stat.best_found) begin
          // the word found before is not the last one
          if (!stat.have_pend || stat.out_free) begin
            cmd.out_load   = stat.have_pend;
            cmd.out_status = ST_OK;
            cmd.out_lst    = 1'b1;
            cmd.take_best  = 1'b1;
            if (stat.list_near) begin
              state_nxt = S_LFIN;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_LSCAN;
            end
          end
        end else if (stat.out_free) begin
          // nothing more: close the list
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_lst    = stat.have_pend;
          cmd.out_status = stat.have_pend ? ST_OK : ST_MISS;
          state_nxt      = S_IDLE;
        end
      end
      S_LFIN: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_lst    = 1'b1;
          cmd.out_status = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/neighbor_position_table.sv =====
// Channel | Direction | tdata (low bit up)                               | tuser  | tlast
// in_     | input     | address, now_time, cutoff_time, pos_x/y/z_in     | op     | -
// out_    | output    | pos_x/y/z_out, listed_address, oldest_stamp      | status | last
//
// One request at a time; a walk reads one slot a cycle.
// Set, remove, get: find walk, apply step, oldest-stamp walk, then a position read on a get hit;
// age out: age walk and oldest-stamp walk; clear and unused codes one walk. List: oldest-stamp
// walk, then a walk per listed address and one closing walk, 16 list walks at most.
// Reset (rst_n low, synchronous) empties the table at once; no clearing pass.
// A stalled output word holds; the next request is taken while the last word waits.
module neighbor_position_table #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // address[31:0], now_time[79:32], cutoff_time[127:80], pos_x_in[159:128],
  // pos_y_in[191:160], pos_z_in[223:192]
  input  logic [npt_pkg::IN_DATA_W-1:0]  in_tdata,
  // op[2:0]
  input  logic [npt_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pos_x_out[31:0], pos_y_out[63:32], pos_z_out[95:64], listed_address[127:96],
  // oldest_stamp[175:128]
  output logic [npt_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [npt_pkg::STATUS_W-1:0]   out_tuser,
  output logic                           out_tlast
);
  import npt_pkg::*;

  npt_cmd_t  cmd;
  npt_stat_t stat;

  // sequencer
  npt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot store, walk logic and output register
  npt_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== test/npt_table_check.sv =====
// Watches both channels of the neighbor table, keeps a mirror of the table,
// predicts the result words of every accepted request and compares them in order.
module npt_table_check #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [npt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [npt_pkg::OP_W-1:0]       in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [npt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [npt_pkg::STATUS_W-1:0]   out_tuser,
  input  logic                           out_tlast,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding,
  output int unsigned                    words_checked
);
  import npt_pkg::*;

  // one result word as the block should give it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [POS_W-1:0]    z;
    logic [ADDR_W-1:0]   listed;
    logic [TIME_W-1:0]   oldest;
    logic                last;
  } result_word_t;

  // mirror of the neighbor table
  logic [ENTRIES-1:0] live;
  logic [ADDR_W-1:0]  keys   [ENTRIES];
  logic [TIME_W-1:0]  stamps [ENTRIES];
  logic [POS_W-1:0]   pos_x  [ENTRIES];
  logic [POS_W-1:0]   pos_y  [ENTRIES];
  logic [POS_W-1:0]   pos_z  [ENTRIES];

  result_word_t due_words[$];
  int unsigned  fail_count = 0;
  int unsigned  checked = 0;

  // smallest stamp still stored, all ones when the table is empty
  function automatic logic [TIME_W-1:0] oldest_live_stamp();
    logic [TIME_W-1:0] m;
    m = '1;
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && stamps[i] < m) m = stamps[i];
    return m;
  endfunction

  // apply one request to the mirror and queue the words it should give
  task automatic predict_request(input logic [OP_W-1:0] op,
                                 input logic [IN_DATA_W-1:0] d);
    logic [ADDR_W-1:0] key;
    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] cut_t;
    logic [ADDR_W-1:0] prev;
    logic              have_prev;
    logic              done;
    int                hit;
    int                slot;
    int                pick;
    result_word_t      w;
    result_word_t      words[$];
    key   = d[31:0];
    now_t = d[79:32];
    cut_t = d[127:80];
    hit = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && live[i] && keys[i] == key) hit = i;
    w = '0;
    w.status = ST_OK;
    w.last = 1'b1;
    case (op)
      OP_SET: begin
        slot = hit;
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !live[i]) slot = i;
        if (slot < 0) begin
          w.status = ST_FULL;
        end else begin
          live[slot]   = 1'b1;
          keys[slot]   = key;
          stamps[slot] = now_t;
          pos_x[slot]  = d[159:128];
          pos_y[slot]  = d[191:160];
          pos_z[slot]  = d[223:192];
        end
      end
      OP_GET: begin
        if (hit < 0) begin
          w.status = ST_MISS;
        end else begin
          w.x = pos_x[hit];
          w.y = pos_y[hit];
          w.z = pos_z[hit];
        end
      end
      OP_REMOVE: begin
        if (hit < 0) w.status = ST_MISS;
        else live[hit] = 1'b0;
      end
      OP_AGE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (live[i] && stamps[i] <= cut_t) live[i] = 1'b0;
      end
      OP_CLEAR: live = '0;
      OP_LIST: begin
        // ascending walk: smallest key above the one emitted last
        have_prev = 1'b0;
        prev = '0;
        done = 1'b0;
        while (!done && words.size() < MAX_RESULTS) begin
          pick = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (live[i] && !(have_prev && keys[i] <= prev))
              if (pick < 0 || keys[i] < keys[pick]) pick = i;
          if (pick < 0) begin
            done = 1'b1;
          end else begin
            prev = keys[pick];
            have_prev = 1'b1;
            w.listed = prev;
            w.last = 1'b0;
            words = {words, w};
          end
        end
        if (words.size() == 0) begin
          w.status = ST_MISS;
          w.listed = '0;
          w.last = 1'b1;
          words = {words, w};
        end else begin
          words[words.size() - 1].last = 1'b1;
        end
      end
      default: w.status = ST_MISS;
    endcase
    if (op != OP_LIST) words = {words, w};
    // every word carries the oldest stamp after the request
    foreach (words[k]) begin
      w = words[k];
      w.oldest = oldest_live_stamp();
      due_words = {due_words, w};
    end
  endtask

  task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // results first: a word leaving at this edge belongs to an earlier request
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        checked++;
        if (due_words.size() == 0) begin
          fail_count++;
          $display("%0t: word with nothing expected, expected none, got status %h data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = due_words.pop_front();
          compare_field("status", TIME_W'(want.status), TIME_W'(out_tuser));
          compare_field("pos_x", TIME_W'(want.x), TIME_W'(out_tdata[31:0]));
          compare_field("pos_y", TIME_W'(want.y), TIME_W'(out_tdata[63:32]));
          compare_field("pos_z", TIME_W'(want.z), TIME_W'(out_tdata[95:64]));
          compare_field("listed_address", TIME_W'(want.listed),
                        TIME_W'(out_tdata[127:96]));
          compare_field("oldest_stamp", want.oldest, out_tdata[175:128]);
          compare_field("last", TIME_W'(want.last), TIME_W'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) predict_request(in_tuser, in_tdata);
    end else begin
      // table starts empty after reset
      live = '0;
    end
    mismatches <= fail_count;
    outstanding <= due_words.size();
    words_checked <= checked;
  end

endmodule

// ===== test/neighbor_position_table_test.sv =====
// Stimulus and verdict for the neighbor table; checking lives in npt_table_check.
module neighbor_position_table_test;
  import npt_pkg::*;

  localparam int TABLE_SIZE  = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 400;   // longer than a full 16-walk list
  localparam int HOLD_CYCLES = 500;
  localparam int POOL_SIZE   = 22;
  localparam int PHASE_ITEMS = 120;

  // unused request codes
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam logic [POS_W-1:0]  POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [POS_W-1:0]  POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  out_tlast;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned words_checked;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_armed = 0;
  int unsigned hold_taken = 0;
  int unsigned cycles = 0;
  int unsigned requests = 0;

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  logic [TIME_W-1:0] clock_now;

  neighbor_position_table #(.ENTRIES(TABLE_SIZE)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  npt_table_check #(.ENTRIES(TABLE_SIZE)) table_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("neighbor_position_table_test: errors");
      $finish;
    end
  end

  // result side: random back-pressure, plus long hold-offs on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed != hold_taken) begin
        hold_taken = hold_armed;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return {16'($urandom), $urandom};
  endfunction

  // offer one request word and wait for it to be taken
  task automatic offer(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                       input logic [TIME_W-1:0] now_t, input logic [TIME_W-1:0] cut_t,
                       input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                       input logic [POS_W-1:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {z, y, x, cut_t, now_t, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests++;
  endtask

  // stop offering until every expected word is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // one random request: mostly pool keys so gets and removes hit
  task automatic random_request();
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] cut_t;
    logic [TIME_W-1:0] back;
    pick = $urandom_range(99);
    if (pick < 34)      op = OP_SET;
    else if (pick < 56) op = OP_GET;
    else if (pick < 68) op = OP_REMOVE;
    else if (pick < 76) op = OP_AGE;
    else if (pick < 79) op = OP_CLEAR;
    else if (pick < 96) op = OP_LIST;
    else                op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    if ($urandom_range(99) < 85) addr = addr_pool[$urandom_range(POOL_SIZE-1)];
    else addr = $urandom;
    if ($urandom_range(99) < 4) clock_now = rand_time();
    else clock_now = clock_now + TIME_W'($urandom_range(400, 1));
    back = TIME_W'($urandom_range(6000));
    if ($urandom_range(99) < 10) cut_t = rand_time();
    else cut_t = (clock_now < back) ? '0 : clock_now - back;
    offer(op, addr, clock_now, cut_t, $urandom, $urandom, $urandom);
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 1'b0;
    clock_now = TIME_W'(1000);
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 28;
    recv_idle = 82;

    // empty-table misses, address zero, overwrite, unused codes
    offer(OP_LIST, '0, '0, '0, '0, '0, '0);
    offer(OP_GET, ADDR_W'(5), '0, '0, '0, '0, '0);
    offer(OP_REMOVE, ADDR_W'(5), '0, '0, '0, '0, '0);
    offer(OP_SET, '0, '0, TIME_MAX, POS_MIN, POS_MIN, POS_MIN);
    offer(OP_SET, '0, TIME_W'(3), '0, '1, '0, POS_W'(1));
    offer(OP_SPARE_A, '0, '0, '0, '0, '0, '0);
    offer(OP_SPARE_B, '1, TIME_MAX, TIME_MAX, '1, '1, '1);
    // fill in descending key order; first key is all ones with the top stamp
    for (int k = 1; k < TABLE_SIZE; k++)
      offer(OP_SET, ADDR_W'(TABLE_SIZE - k) * 32'h1111_1111,
            (k == 1) ? TIME_MAX : TIME_W'(10 * k), '0,
            (k == 1) ? POS_MAX : $urandom, (k == 1) ? POS_MAX : $urandom,
            (k == 1) ? POS_MAX : $urandom);
    offer(OP_SET, 32'hDEAD_BEEF, TIME_W'(99), '0, '1, '1, '1);
    offer(OP_LIST, '0, '0, '0, '0, '0, '0);
    offer(OP_GET, '1, '0, '0, '0, '0, '0);
    offer(OP_AGE, '0, '0, TIME_W'(50), '0, '0, '0);
    offer(OP_CLEAR, '0, '0, '0, '0, '0, '0);
    drain_results();

    // random traffic under three pacing mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 28;
          recv_idle = 82;
        end
        1: begin
          send_idle = 82;
          recv_idle = 28;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          hold_armed++;   // block fills while results are held off
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        random_request();
      end
      drain_results();
    end

    repeat (SETTLE) @(posedge clk);
    $display("covered %0d requests: corner cases, full table, lists, aging, clears,",
             requests);
    $display("unused codes, three pacing mixes and a long result hold; %0d words checked",
             words_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("neighbor_position_table_test: clean");
    end else begin
      $display("neighbor_position_table_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/npt_pkg.sv
rtl/npt_dpath.sv
rtl/npt_ctrl.sv
rtl/neighbor_position_table.sv
test/npt_table_check.sv
test/neighbor_position_table_test.sv
